// ===== rtl/tlpm_pkg.sv =====
// shared types and constants of the two-level page table mapper
`timescale 1ns / 1ps

package tlpm_pkg;

  localparam int FRAME_W        = 20;
  localparam int IDX_W          = 10;
  localparam int ATTR_W         = 12;
  localparam int ENTRY_W        = 32;
  localparam int ENTRIES        = 1024;
  localparam int POOL_PAGES_DEF = 16;

  localparam logic [FRAME_W-1:0] RST_POOL_BASE  = 20'd256;
  localparam logic [FRAME_W-1:0] RST_FIRST_FREE = 20'd256;
  // present | write | user
  localparam logic [ATTR_W-1:0]  DIR_ATTRS      = 12'h007;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_POOL    = 2'd1,
    ST_NOTABLE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR_RD,
    S_DIR_EVAL,
    S_TAB_WR,
    S_TAB_CLR
  } ctrl_state_t;

  typedef struct packed {
    logic               cmd;
    logic [FRAME_W-1:0] root_frame;
    logic [31:0]        virt_addr;
    logic [31:0]        phys_addr;
    logic [ATTR_W-1:0]  attrs;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] old_frame;
    logic               table_allocated;
    logic               flush_tlb;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    clr_wr;
    logic    dir_eval;
    logic    dir_alloc;
    logic    tab_rd;
    logic    tab_wr;
    logic    tab_clr;
    logic    finish;
    status_t fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic root_ok;
    logic is_unmap;
    logic tf_zero;
    logic tf_ok;
    logic nff_ok;
  } dp_stat_t;

endpackage

// ===== rtl/two_level_page_table_mapper.sv =====
// top level of the two-level page table mapper
`timescale 1ns / 1ps

// Maps or unmaps one 4 KiB page per transaction in two-level page tables
// kept in an on-chip pool of POOL_PAGES table pages (1024 entries each).
// A transaction is taken when start is high and busy is low. Its single
// result appears on out_item for exactly one cycle with out_valid high and
// must be captured then; the receiver cannot stall. The result is registered
// from the last state of the request: S_TAB_WR or S_TAB_CLR when the table
// is reached, S_DIR_EVAL when the directory entry rejects the request and
// S_DIR_RD when the root frame lies outside the pool. busy stays high
// through that last state, so a new transaction is taken only once the last
// is done (early rejections end sooner); the limit is the single port of
// the entry memory, serving the dependent directory read, table read and write
// in turn. After reset a clearing pass zeroes all POOL_PAGES * 1024 entries,
// with busy high. Configuration is to be written by the user only while no
// transaction is in flight (the pass has none); the block does not enforce it.
module two_level_page_table_mapper import tlpm_pkg::*; #(
  parameter int POOL_PAGES = POOL_PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  tlpm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  tlpm_dp #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/tlpm_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps

module tlpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tlpm_dp.sv =====
// datapath: request registers, pool checks, entry memory and result registers
`timescale 1ns / 1ps

module tlpm_dp import tlpm_pkg::*; #(
  parameter int POOL_PAGES = POOL_PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_wdata,
  input  in_item_t             in_item,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic                 out_valid,
  output out_item_t            out_item
);

  localparam int DEPTH  = POOL_PAGES * ENTRIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [FRAME_W-1:0] base_r;
  logic [FRAME_W-1:0] nff_r;
  in_item_t           req_r;
  logic [FRAME_W-1:0] tframe_r;
  logic               alloc_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [FRAME_W-1:0] mem_frame;
  logic [IDX_W-1:0]   dir_idx;
  logic [IDX_W-1:0]   tab_idx;

  function automatic logic in_pool(input logic [FRAME_W-1:0] frame,
                                   input logic [FRAME_W-1:0] base);
    logic [FRAME_W-1:0] diff;
    diff = frame - base;
    return (frame >= base) && (diff < FRAME_W'(POOL_PAGES));
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [FRAME_W-1:0] frame,
                                             input logic [FRAME_W-1:0] base,
                                             input logic [IDX_W-1:0]   idx);
    logic [FRAME_W-1:0] diff;
    diff = frame - base;
    return ADDR_W'({diff, idx});
  endfunction

  assign dir_idx   = req_r.virt_addr[31:22];
  assign tab_idx   = req_r.virt_addr[21:12];
  assign mem_frame = mem_rdata[ENTRY_W-1:ENTRY_W-FRAME_W];

  assign stat_o.clr_last = (clr_cnt_r == LAST_ADDR);
  assign stat_o.root_ok  = in_pool(req_r.root_frame, base_r);
  assign stat_o.is_unmap = (req_r.cmd == CMD_UNMAP);
  assign stat_o.tf_zero  = (mem_frame == '0);
  assign stat_o.tf_ok    = in_pool(mem_frame, base_r);
  assign stat_o.nff_ok   = in_pool(nff_r, base_r);

  // one memory port shared by clearing, directory and table accesses
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = slot(req_r.root_frame, base_r, dir_idx);
    mem_wdata = '0;
    if (cmd_i.clr_wr) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_r;
    end else if (cmd_i.dir_alloc) begin
      mem_we    = 1'b1;
      mem_wdata = {nff_r, DIR_ATTRS};
    end else if (cmd_i.tab_rd) begin
      mem_addr = slot(mem_frame, base_r, tab_idx);
    end else if (cmd_i.tab_wr) begin
      mem_we    = 1'b1;
      mem_addr  = slot(tframe_r, base_r, tab_idx);
      mem_wdata = {req_r.phys_addr[31:12], req_r.attrs};
    end else if (cmd_i.tab_clr) begin
      mem_we   = 1'b1;
      mem_addr = slot(tframe_r, base_r, tab_idx);
    end
  end

  tlpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= RST_POOL_BASE;
      nff_r       <= RST_FIRST_FREE;
      alloc_r     <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_POOL_BASE) begin
        base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_FIRST_FREE) begin
        nff_r <= cfg_wdata;
      end else if (cmd_i.dir_alloc) begin
        nff_r <= nff_r + 1'b1;
      end
      if (cmd_i.load) begin
        alloc_r <= 1'b0;
      end else if (cmd_i.dir_alloc) begin
        alloc_r <= 1'b1;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      out_valid_r <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_r <= in_item;
    end
    if (cmd_i.dir_eval) begin
      tframe_r <= cmd_i.dir_alloc ? nff_r : mem_frame;
    end
    if (cmd_i.finish) begin
      out_r.status          <= cmd_i.fin_status;
      out_r.old_frame       <= cmd_i.tab_clr ? mem_frame : '0;
      out_r.table_allocated <= alloc_r;
      out_r.flush_tlb       <= cmd_i.tab_wr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  // a flush only ever comes with a successful map
  a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.flush_tlb) |-> (out_r.status == ST_OK))
    else $error("flush reported with failing status");

  // an allocation is always followed by the table write
  a_alloc_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.table_allocated) |-> out_r.flush_tlb)
    else $error("table allocated without completing the map");

  // old frame only from a successful unmap
  a_old_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.old_frame != '0) |->
      (out_r.status == ST_OK && !out_r.flush_tlb))
    else $error("old frame reported outside a successful unmap");

  // the bump pointer moves by one unless reloaded
  a_bump_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_we) && nff_r != $past(nff_r)) |->
      (nff_r == $past(nff_r) + 1'b1))
    else $error("allocator pointer jumped");
`endif

endmodule

// ===== rtl/tlpm_ctrl.sv =====
// controller: sequences clearing, directory lookup and table update
`timescale 1ns / 1ps

module tlpm_ctrl import tlpm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat_i.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_DIR_RD;
      end
      S_DIR_RD: begin
        state_nxt = stat_i.root_ok ? S_DIR_EVAL : S_IDLE;
      end
      S_DIR_EVAL: begin
        if (stat_i.is_unmap) begin
          state_nxt = (stat_i.tf_zero || !stat_i.tf_ok) ? S_IDLE : S_TAB_CLR;
        end else if (stat_i.tf_zero) begin
          state_nxt = stat_i.nff_ok ? S_TAB_WR : S_IDLE;
        end else begin
          state_nxt = stat_i.tf_ok ? S_TAB_WR : S_IDLE;
        end
      end
      S_TAB_WR:  state_nxt = S_IDLE;
      S_TAB_CLR: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.fin_status = ST_OK;
    busy             = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_DIR_RD: begin
        if (!stat_i.root_ok) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_POOL;
        end
      end
      S_DIR_EVAL: begin
        cmd_o.dir_eval = 1'b1;
        if (stat_i.is_unmap) begin
          if (stat_i.tf_zero) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_NOTABLE;
          end else if (!stat_i.tf_ok) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_POOL;
          end else begin
            cmd_o.tab_rd = 1'b1;
          end
        end else if (stat_i.tf_zero) begin
          // missing table: take one from the allocator if it is still in the pool
          if (stat_i.nff_ok) begin
            cmd_o.dir_alloc = 1'b1;
          end else begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_POOL;
          end
        end else if (!stat_i.tf_ok) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_POOL;
        end
      end
      S_TAB_WR: begin
        cmd_o.tab_wr = 1'b1;
        cmd_o.finish = 1'b1;
      end
      S_TAB_CLR: begin
        cmd_o.tab_clr = 1'b1;
        cmd_o.finish  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== tb/sv/two_level_page_table_mapper_tb.sv =====
// self-checking testbench of the two-level page table mapper
`timescale 1ns / 1ps

module two_level_page_table_mapper_tb;
  import tlpm_pkg::*;

  localparam int POOL_N     = POOL_PAGES_DEF;
  localparam int SLOT_W     = $clog2(POOL_N * ENTRIES);
  localparam int CYCLE_CAP  = 600000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_BASE;
  logic [FRAME_W-1:0]   cfg_wdata = '0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_valid;
  out_item_t            out_item;

  // shadow of the block: entry memory, allocator and pool window
  logic [ENTRY_W-1:0] entry_mem [0:POOL_N*ENTRIES-1];
  logic [FRAME_W-1:0] alloc_ptr = RST_FIRST_FREE;
  logic [FRAME_W-1:0] pool_lo = RST_POOL_BASE;

  out_item_t pending_results[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;

  two_level_page_table_mapper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("** two_level_page_table_mapper: FAILED **");
      $finish;
    end
  end

  function automatic bit frame_in_pool(logic [FRAME_W-1:0] f);
    logic [FRAME_W-1:0] off;
    off = f - pool_lo;
    return (f >= pool_lo) && (off < FRAME_W'(POOL_N));
  endfunction

  function automatic logic [SLOT_W-1:0] entry_slot(logic [FRAME_W-1:0] f,
                                                   logic [IDX_W-1:0] idx);
    logic [FRAME_W-1:0] off;
    off = f - pool_lo;
    return SLOT_W'({off, idx});
  endfunction

  // applies one request to the shadow tables and returns its result
  function automatic out_item_t walk_and_update(in_item_t r);
    out_item_t          res;
    logic [IDX_W-1:0]   dir_idx;
    logic [IDX_W-1:0]   tab_idx;
    logic [FRAME_W-1:0] tab_frame;
    logic [SLOT_W-1:0]  dir_slot;
    logic [SLOT_W-1:0]  tab_slot;
    res = '0;
    res.status = ST_OK;
    dir_idx = r.virt_addr[31:22];
    tab_idx = r.virt_addr[21:12];
    if (!frame_in_pool(r.root_frame)) begin
      res.status = ST_POOL;
    end else begin
      dir_slot = entry_slot(r.root_frame, dir_idx);
      tab_frame = entry_mem[dir_slot][31:12];
      if (r.cmd == CMD_MAP) begin
        // only a zero frame field counts as a missing table
        if (tab_frame == '0) begin
          if (frame_in_pool(alloc_ptr)) begin
            tab_frame = alloc_ptr;
            entry_mem[dir_slot] = {tab_frame, DIR_ATTRS};
            alloc_ptr = alloc_ptr + 1'b1;
            res.table_allocated = 1'b1;
          end else begin
            res.status = ST_POOL;
          end
        end else if (!frame_in_pool(tab_frame)) begin
          res.status = ST_POOL;
        end
        if (res.status == ST_OK) begin
          entry_mem[entry_slot(tab_frame, tab_idx)] = {r.phys_addr[31:12], r.attrs};
          res.flush_tlb = 1'b1;
        end
      end else begin
        if (tab_frame == '0) begin
          res.status = ST_NOTABLE;
        end else if (!frame_in_pool(tab_frame)) begin
          res.status = ST_POOL;
        end else begin
          tab_slot = entry_slot(tab_frame, tab_idx);
          res.old_frame = entry_mem[tab_slot][31:12];
          entry_mem[tab_slot] = '0;
        end
      end
    end
    return res;
  endfunction

  function automatic in_item_t page_req(logic cmd, logic [FRAME_W-1:0] root,
                                        logic [31:0] virt, logic [31:0] phys,
                                        logic [ATTR_W-1:0] attrs);
    in_item_t r;
    r.cmd = cmd;
    r.root_frame = root;
    r.virt_addr = virt;
    r.phys_addr = phys;
    r.attrs = attrs;
    return r;
  endfunction

  // mostly requests into a few directories of the first pool pages, so that
  // tables fill up and unmaps find something
  function automatic in_item_t rand_page_req();
    in_item_t         r;
    int               pick;
    logic [IDX_W-1:0] dir_idx;
    logic [IDX_W-1:0] tab_idx;
    r.cmd = ($urandom_range(0, 99) < 55) ? CMD_MAP : CMD_UNMAP;
    pick = $urandom_range(0, 99);
    if (pick < 85)
      r.root_frame = pool_lo + FRAME_W'($urandom_range(0, 1));
    else if (pick < 92)
      r.root_frame = pool_lo + FRAME_W'($urandom_range(0, POOL_N - 1));
    else
      r.root_frame = FRAME_W'($urandom);
    case ($urandom_range(0, 4))
      0: dir_idx = '0;
      1: dir_idx = 10'd1;
      2: dir_idx = 10'd512;
      3: dir_idx = '1;
      default: dir_idx = IDX_W'($urandom);
    endcase
    tab_idx = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 7));
    r.virt_addr = {dir_idx, tab_idx, 12'($urandom)};
    r.phys_addr = $urandom;
    r.attrs = ATTR_W'($urandom);
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input in_item_t r);
    start <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy);
    pending_results.push_back(walk_and_update(r));
    @(negedge clk);
  endtask

  task automatic set_pool(input logic [FRAME_W-1:0] base, input logic [FRAME_W-1:0] first);
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0 || busy) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_POOL_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_FIRST_FREE;
    cfg_wdata <= first;
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_lo = base;
    alloc_ptr = first;
  endtask

  task automatic run_random(input int n, input bit with_gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < n) begin
          send_req(rand_page_req());
          sent++;
        end
      end
      if (with_gaps && $urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic test_map_unmap_basic();
    set_pool(20'd256, 20'd257);
    send_req(page_req(CMD_MAP, 20'd256, 32'h0040_1000, 32'hFFFF_FFFF, 12'hFFF));
    send_req(page_req(CMD_MAP, 20'd256, 32'h007F_F000, 32'h0000_0000, 12'h000));
    send_req(page_req(CMD_UNMAP, 20'd256, 32'h0040_1000, 32'h0, 12'h0));
    send_req(page_req(CMD_UNMAP, 20'd256, 32'h0040_1000, 32'h0, 12'h0));
    // no table behind this directory entry
    send_req(page_req(CMD_UNMAP, 20'd256, 32'h0080_0000, 32'h0, 12'h0));
    // directory frames just outside the pool and at the field extremes
    send_req(page_req(CMD_MAP, 20'd255, 32'h0040_1000, 32'h1000, 12'h1));
    send_req(page_req(CMD_MAP, 20'd272, 32'h0040_1000, 32'h1000, 12'h1));
    send_req(page_req(CMD_UNMAP, 20'hFFFFF, 32'h0040_1000, 32'h0, 12'h0));
    send_req(page_req(CMD_UNMAP, 20'h00000, 32'h0040_1000, 32'h0, 12'h0));
    send_req(page_req(CMD_MAP, 20'd271, 32'hFFFF_FFFF, 32'h1234_5678, 12'hABC));
    send_req(page_req(CMD_UNMAP, 20'd271, 32'hFFFF_F000, 32'h0, 12'h0));
  endtask

  // the table at frame 257 is reused as a directory through root 257
  task automatic test_alias_and_presence();
    // entry points outside the pool
    send_req(page_req(CMD_MAP, 20'd256, 32'h0040_7000, 32'h0000_1000, 12'h007));
    send_req(page_req(CMD_MAP, 20'd257, 32'h01C0_0000, 32'h0000_2000, 12'h003));
    send_req(page_req(CMD_UNMAP, 20'd257, 32'h01C0_0000, 32'h0, 12'h0));
    // nonzero frame with the present bit clear still counts as a table
    send_req(page_req(CMD_MAP, 20'd256, 32'h0040_8000, 32'h0010_A000, 12'h000));
    send_req(page_req(CMD_MAP, 20'd257, 32'h0200_3000, 32'h5555_5000, 12'h555));
    send_req(page_req(CMD_UNMAP, 20'd257, 32'h0200_3000, 32'h0, 12'h0));
    // zero frame with the present bit set is still missing
    send_req(page_req(CMD_MAP, 20'd256, 32'h0040_9000, 32'h0000_0000, 12'h001));
    send_req(page_req(CMD_MAP, 20'd257, 32'h0240_0000, 32'hAAAA_A000, 12'h2AA));
  endtask

  task automatic test_pool_exhaustion();
    set_pool(20'd256, 20'd271);
    send_req(page_req(CMD_MAP, 20'd256, 32'h9600_0000, 32'h0000_3000, 12'h0F0));
    send_req(page_req(CMD_MAP, 20'd256, 32'h9640_0000, 32'h0000_4000, 12'h0F0));
    set_pool(20'd256, 20'hFFFFF);
    send_req(page_req(CMD_MAP, 20'd256, 32'h9680_0000, 32'h0000_5000, 12'h00F));
    // allocator wraps from the top frame to zero, which is outside the pool
    set_pool(20'hFFFF0, 20'hFFFFF);
    send_req(page_req(CMD_MAP, 20'hFFFF0, 32'h96C0_0000, 32'h0000_6000, 12'h00F));
    send_req(page_req(CMD_MAP, 20'hFFFF0, 32'h9700_0000, 32'h0000_7000, 12'h00F));
    // old table frames now lie below the moved pool
    send_req(page_req(CMD_MAP, 20'hFFFF0, 32'h0040_0000, 32'h0000_8000, 12'h00F));
  endtask

  task automatic test_random_settings();
    logic [FRAME_W-1:0] base;
    set_pool(20'd256, 20'd256);
    run_random(260, 1'b1);
    set_pool(20'd0, 20'd0);
    run_random(200, 1'b1);
    set_pool(20'd0, 20'd3);
    run_random(150, 1'b0);
    set_pool(20'hFFFF0, 20'hFFFF0);
    run_random(200, 1'b1);
    set_pool(20'hFFFFF, 20'hFFFFF);
    run_random(150, 1'b1);
    base = FRAME_W'($urandom);
    set_pool(base, base + FRAME_W'($urandom_range(0, 4)));
    run_random(200, 1'b1);
    // allocator already past the pool
    set_pool(20'd256, 20'd300);
    run_random(100, 1'b1);
    set_pool(20'd256, 20'd256);
    run_random(300, 1'b0);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          err_cnt++;
        end
        if (out_item.old_frame !== want.old_frame) begin
          $error("old_frame: expected %h, got %h", want.old_frame, out_item.old_frame);
          err_cnt++;
        end
        if (out_item.table_allocated !== want.table_allocated) begin
          $error("table_allocated: expected %0b, got %0b",
                 want.table_allocated, out_item.table_allocated);
          err_cnt++;
        end
        if (out_item.flush_tlb !== want.flush_tlb) begin
          $error("flush_tlb: expected %0b, got %0b", want.flush_tlb, out_item.flush_tlb);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_N * ENTRIES; i++) entry_mem[SLOT_W'(i)] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // clearing pass of the entry memory
    while (busy) @(negedge clk);
    test_map_unmap_basic();
    test_alias_and_presence();
    test_pool_exhaustion();
    test_random_settings();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("** two_level_page_table_mapper: PASSED **");
    end else begin
      $display("** two_level_page_table_mapper: FAILED **");
    end
    $finish;
  end

endmodule

// ===== two_level_page_table_mapper.f =====
rtl/tlpm_pkg.sv
rtl/tlpm_ram.sv
rtl/tlpm_dp.sv
rtl/tlpm_ctrl.sv
rtl/two_level_page_table_mapper.sv
tb/sv/two_level_page_table_mapper_tb.sv
